// File: design/modulo_hash_bucket_table_macros.svh
// Assertion macros used by the bucket table design file
`ifndef MODULO_HASH_BUCKET_TABLE_MACROS_SVH
`define MODULO_HASH_BUCKET_TABLE_MACROS_SVH

// Implication checked on every clock edge outside reset
`define MHBT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset
`define MHBT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/mhbt_pkg.sv
// ----------------------------------------------------------------------------
// mhbt_pkg
// Types and codes shared by the modulo hash bucket table.
// ----------------------------------------------------------------------------
package mhbt_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam int KEY_W = 31;
  localparam int PAY_W = 32;
  localparam int TS_W  = 9;

  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [PAY_W-1:0] found_payload;
  } rsp_t;

endpackage

// File: design/modulo_hash_bucket_table.sv
// ----------------------------------------------------------------------------
// modulo_hash_bucket_table
// Bucketed key table hashed by key modulo a configured table size.
// ----------------------------------------------------------------------------
// One transaction at a time: busy rises the cycle after start and falls when
// the result strobe fires. A transaction passes through the bit-serial
// remainder unit (one shift step per key bit and the hand-off), then a count
// read, a count evaluation, a walk over the bucket's entries through the
// registered-read entry RAM (a read state and an evaluate state per entry)
// and a state to post the result; a new transaction is taken only once the
// last result has been posted. The result is shown for one cycle on
// result_valid and cannot be held off. Bucket counts reset by a clearing
// pass over all BUCKETS counts after reset, while busy is held high.
module modulo_hash_bucket_table
  import mhbt_pkg::*;
#(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  req_t             req,
  output logic             busy,
  output logic             result_valid,
  output rsp_t             rsp,
  input  logic             cfg_we,
  input  logic [TS_W-1:0]  cfg_data
);

  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CW    = $clog2(WAYS + 1);
  localparam int SLOTS = BUCKETS * (2 ** WW);
  localparam int SW    = $clog2(SLOTS);
  localparam int DW    = $clog2(BUCKETS + 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_CRD   = 4'd3;
  localparam logic [3:0] S_CNT   = 4'd4;
  localparam logic [3:0] S_ERD   = 4'd5;
  localparam logic [3:0] S_EVAL  = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [3:0]       state;
  logic [TS_W-1:0]  table_size;
  req_t             cur;
  logic [BW-1:0]    bkt;
  logic [CW-1:0]    cnt;
  logic [CW-1:0]    rd_i;
  logic [CW-1:0]    wr_i;
  logic [1:0]       status;
  logic [PAY_W-1:0] found;
  logic [BW-1:0]    clr_addr;

  logic [DW-1:0]    divisor;
  logic             div_start;
  logic             div_done;
  logic [DW-1:0]    div_rem;

  logic             cnt_we;
  logic [BW-1:0]    cnt_waddr;
  logic [CW-1:0]    cnt_wdata;
  logic [CW-1:0]    cnt_rdata;

  logic             ent_we;
  logic [SW-1:0]    ent_waddr;
  logic [SW-1:0]    ent_raddr;
  logic [KEY_W+PAY_W-1:0] ent_wdata;
  logic [KEY_W+PAY_W-1:0] ent_rdata;
  logic [KEY_W-1:0] rd_key;

  // clamp divisor to 1..BUCKETS
  always_comb begin
    if (table_size == '0) begin
      divisor = DW'(1);
    end else if (32'(table_size) > BUCKETS) begin
      divisor = DW'(BUCKETS);
    end else begin
      divisor = DW'(table_size);
    end
  end

  assign div_start = (state == S_IDLE) && start;

  mhbt_divider #(.DIV_W(DW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (req.key),
    .divisor   (divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  mhbt_ram #(.WIDTH(CW), .DEPTH(BUCKETS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (bkt),
    .rdata (cnt_rdata)
  );

  mhbt_ram #(.WIDTH(KEY_W+PAY_W), .DEPTH(SLOTS)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  assign rd_key    = ent_rdata[KEY_W+PAY_W-1:PAY_W];
  assign ent_raddr = SW'({bkt, rd_i[WW-1:0]} );

  // memory write control
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = bkt;
    cnt_wdata = '0;
    ent_we    = 1'b0;
    ent_waddr = SW'({bkt, wr_i[WW-1:0]});
    ent_wdata = {cur.key, cur.payload};
    unique case (state)
      S_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_addr;
      end
      S_CNT: begin
        if (cur.op == OP_INSERT && cnt_rdata < CW'(WAYS)) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_rdata + 1'b1;
          ent_we    = 1'b1;
          ent_waddr = SW'({bkt, cnt_rdata[WW-1:0]});
        end
      end
      S_EVAL: begin
        if (cur.op == OP_REMOVE && rd_key != cur.key) begin
          ent_we    = 1'b1;
          ent_wdata = ent_rdata;
        end
      end
      S_DONE: begin
        if (cur.op == OP_REMOVE) begin
          cnt_we    = 1'b1;
          cnt_wdata = wr_i;
        end
      end
      default: ;
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TS_W'(256);
    end else if (cfg_we) begin
      table_size <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == BUCKETS - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cur   <= req;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            bkt   <= BW'(div_rem);
            state <= S_CRD;
          end
        end
        S_CRD: begin
          state <= S_CNT;
        end
        S_CNT: begin
          cnt    <= cnt_rdata;
          rd_i   <= '0;
          wr_i   <= '0;
          found  <= '0;
          status <= ST_OK;
          unique case (cur.op) inside
            OP_INSERT: begin
              if (cnt_rdata >= CW'(WAYS)) begin
                status <= ST_FULL;
              end
              state <= S_DONE;
            end
            OP_SEARCH, OP_REMOVE: begin
              status <= ST_NOT_FOUND;
              state  <= (cnt_rdata == '0) ? S_DONE : S_ERD;
            end
            default: state <= S_DONE;
          endcase
        end
        S_ERD: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          rd_i  <= rd_i + 1'b1;
          state <= (rd_i + 1'b1 == cnt) ? S_DONE : S_ERD;
          if (cur.op == OP_SEARCH) begin
            if (rd_key == cur.key) begin
              status <= ST_OK;
              found  <= ent_rdata[PAY_W-1:0];
              state  <= S_DONE;
            end
          end else begin
            if (rd_key != cur.key) begin
              wr_i <= wr_i + 1'b1;
            end else begin
              status <= ST_OK;
            end
          end
        end
        S_DONE: begin
          result_valid <= 1'b1;
          rsp.status        <= status;
          rsp.found_payload <= found;
          state             <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

`include "modulo_hash_bucket_table_macros.svh"

  `MHBT_ASSERT_IMP(a_cnt_bound, state == S_CNT, cnt_rdata <= CW'(WAYS))
  `MHBT_ASSERT_NEXT(a_done_strobe, state == S_DONE, result_valid && state == S_IDLE)
  `MHBT_ASSERT_IMP(a_found_zero, result_valid && rsp.status != ST_OK, rsp.found_payload == '0)
  `MHBT_ASSERT_IMP(a_compact, state == S_EVAL, wr_i <= rd_i)

endmodule

// File: design/mhbt_ram.sv
// ----------------------------------------------------------------------------
// mhbt_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module mhbt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/mhbt_divider.sv
// ----------------------------------------------------------------------------
// mhbt_divider
// Restoring remainder unit: key mod divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mhbt_divider
  import mhbt_pkg::*;
#(
  parameter int DIV_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] remainder
);

  localparam int CNT_W = $clog2(KEY_W + 1);

  logic [KEY_W-1:0] shreg;
  logic [DIV_W:0]   rem;
  logic [DIV_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [DIV_W:0]   trial;
  logic [DIV_W+1:0] diff;

  // shift in next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem[DIV_W-1:0], shreg[KEY_W-1]};
    diff  = {1'b0, trial} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        cnt   <= CNT_W'(KEY_W);
        shreg <= dividend;
        rem   <= '0;
        dvs   <= divisor;
      end else if (run) begin
        shreg <= {shreg[KEY_W-2:0], 1'b0};
        rem   <= diff[DIV_W+1] ? trial : diff[DIV_W:0];
        cnt   <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem[DIV_W-1:0];

endmodule

// File: tb/bucket_table_checker.sv
// ----------------------------------------------------------------------------
// bucket_table_checker
// Watches the request and result channels of the bucket table, predicts each
// result from a private copy of the table and compares field by field.
// ----------------------------------------------------------------------------
module bucket_table_checker
  import mhbt_pkg::*;
#(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  req_t            req,
  input  logic            result_valid,
  input  rsp_t            rsp,
  input  logic            cfg_we,
  input  logic [TS_W-1:0] cfg_data,
  output int              fail_count,
  output int              pending
);

  logic [KEY_W-1:0] tbl_keys [BUCKETS][WAYS];
  logic [PAY_W-1:0] tbl_pays [BUCKETS][WAYS];
  int               tbl_fill [BUCKETS];
  logic [TS_W-1:0]  size_reg;
  rsp_t             rsp_queue [$];

  assign pending = rsp_queue.size();

  // Apply one transaction to the table copy and return the expected result
  function automatic rsp_t apply_op(req_t r);
    rsp_t o;
    int   d;
    int   b;
    int   w;
    d = (size_reg < 1) ? 1 : ((size_reg > BUCKETS) ? BUCKETS : int'(size_reg));
    b = int'(r.key % d);
    o.status = ST_OK;
    o.found_payload = '0;
    case (r.op)
      OP_INSERT: begin
        if (tbl_fill[b] >= WAYS) begin
          o.status = ST_FULL;
        end else begin
          tbl_keys[b][tbl_fill[b]] = r.key;
          tbl_pays[b][tbl_fill[b]] = r.payload;
          tbl_fill[b]++;
        end
      end
      OP_SEARCH: begin
        o.status = ST_NOT_FOUND;
        for (int i = 0; i < tbl_fill[b]; i++) begin
          if (tbl_keys[b][i] == r.key) begin
            o.status = ST_OK;
            o.found_payload = tbl_pays[b][i];
            break;
          end
        end
      end
      OP_REMOVE: begin
        w = 0;
        for (int i = 0; i < tbl_fill[b]; i++) begin
          if (tbl_keys[b][i] != r.key) begin
            tbl_keys[b][w] = tbl_keys[b][i];
            tbl_pays[b][w] = tbl_pays[b][i];
            w++;
          end
        end
        o.status = (w < tbl_fill[b]) ? ST_OK : ST_NOT_FOUND;
        tbl_fill[b] = w;
      end
      default: ;
    endcase
    return o;
  endfunction

  // Predict on accepted requests, compare on result strobes
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst) begin
      size_reg <= 9'd256;
      foreach (tbl_fill[i]) tbl_fill[i] = 0;
      rsp_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) size_reg <= cfg_data;
      if (result_valid) begin
        if (rsp_queue.size() == 0) begin
          $display("%0t: unexpected result status=%0d payload=%h", $time,
                   rsp.status, rsp.found_payload);
          fail_count <= fail_count + 1;
        end else begin
          exp_rsp = rsp_queue.pop_front();
          if (rsp.status !== exp_rsp.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_rsp.status, rsp.status);
            fail_count <= fail_count + 1;
          end else if (rsp.found_payload !== exp_rsp.found_payload) begin
            $display("%0t: found_payload expected %h actual %h", $time,
                     exp_rsp.found_payload, rsp.found_payload);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) rsp_queue = {rsp_queue, apply_op(req)};
    end
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives insert, search, remove and no-op transactions into the bucket table
// under several table sizes, with random idle gaps; the checker scores them.
// ----------------------------------------------------------------------------
module testbench;
  import mhbt_pkg::*;

  localparam int  LIMIT = 600000;

  logic            clk;
  logic            rst;
  logic            start;
  req_t            req;
  logic            busy;
  logic            result_valid;
  rsp_t            rsp;
  logic            cfg_we;
  logic [TS_W-1:0] cfg_data;
  int              fail_count;
  int              pending;
  int              cycles;
  logic [KEY_W-1:0] key_pool [16];
  bit              no_idle;

  modulo_hash_bucket_table dut (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy),
    .result_valid(result_valid), .rsp(rsp), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  bucket_table_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .result_valid(result_valid), .rsp(rsp), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // Run-length guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Issue one transaction and hold until it is taken; start returns low
  // between transactions
  task automatic issue(logic [1:0] op, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay);
    @(negedge clk);
    if (!no_idle) begin
      while ($urandom_range(99) < 22) @(negedge clk);
    end
    start <= 1'b1;
    req <= '{op: op, key: key, payload: pay};
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Wait for the table to drain, then write the size register
  task automatic set_size(logic [TS_W-1:0] sz);
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= sz;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random phase; keys drawn mostly from a small pool to force hits
  task automatic random_phase(int n, int idle_free);
    logic [KEY_W-1:0] k;
    logic [1:0]       op;
    int               r;
    foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
    for (int i = 0; i < n; i++) begin
      no_idle = (i < idle_free);
      r = $urandom_range(99);
      k = (r < 80) ? key_pool[$urandom_range(15)] : KEY_W'($urandom);
      r = $urandom_range(99);
      op = (r < 45) ? OP_INSERT : (r < 75) ? OP_SEARCH : (r < 95) ? OP_REMOVE : OP_NOP;
      issue(op, k, $urandom);
    end
    no_idle = 0;
  endtask

  initial begin
    cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    no_idle = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, all ops, full bucket, duplicates, remove-all
    issue(OP_SEARCH, '0, '0);
    issue(OP_INSERT, '0, '1);
    issue(OP_INSERT, '1, 32'h0);
    issue(OP_SEARCH, '1, '1);
    issue(OP_SEARCH, '0, '0);
    issue(OP_NOP, '1, '1);
    for (int i = 0; i < 9; i++) issue(OP_INSERT, KEY_W'(256 * i + 5), 32'hA0 + i);
    issue(OP_INSERT, 31'd5, 32'hDEAD);
    issue(OP_SEARCH, 31'd5, '0);
    issue(OP_REMOVE, 31'd5, '0);
    issue(OP_REMOVE, 31'd5, '0);
    issue(OP_SEARCH, 31'd1029, '0);
    issue(OP_REMOVE, '1, '0);

    // Size zero acts as one; stored entries stay where they were hashed
    set_size(9'd0);
    issue(OP_SEARCH, 31'd1029, '0);
    random_phase(300, 100);
    set_size(9'd511);
    issue(OP_SEARCH, 31'd1029, '0);
    random_phase(300, 0);
    set_size(9'd1);
    random_phase(300, 0);
    set_size(9'd7);
    random_phase(300, 0);
    set_size(9'd256);
    random_phase(300, 0);
    set_size(9'd3);
    random_phase(300, 0);

    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
